>>> hw/rtl/tst_pkg.sv
package tst_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = 8;
    localparam int CNT_W     = 9;
    localparam int ZOOM_W    = 5;
    localparam int COORD_W   = 31;
    localparam int KEY_W     = ZOOM_W + 2 * COORD_W + 1;
    localparam logic [CNT_W-1:0] LIMIT_CAP = 9'd256;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [ZOOM_W-1:0]  zoom;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               scheme;
    } key_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic scan_clr; // restart slot scan
        logic scan_en;  // step slot scan
        logic ascend;   // move key to parent tile
        logic commit;   // apply add/remove, build result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done;
        logic       hit;
        logic       zoom_zero;
        logic [1:0] cmd;
    } dp_stat_t;

endpackage

>>> hw/rtl/tst_if.sv
interface tst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [4:0]  tile_zoom;
    logic [30:0] tile_x;
    logic [30:0] tile_y;
    logic        tile_scheme;
    modport source (output valid, cmd, tile_zoom, tile_x, tile_y, tile_scheme, input ready);
    modport sink   (input valid, cmd, tile_zoom, tile_x, tile_y, tile_scheme, output ready);
endinterface

interface tst_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slot_index;
    logic [1:0]  status;
    logic [4:0]  found_zoom;
    logic [30:0] found_x;
    logic [30:0] found_y;
    logic        found_scheme;
    logic [8:0]  occupied;
    modport source (output valid, slot_index, status, found_zoom, found_x, found_y,
                    found_scheme, occupied, input ready);
    modport sink   (input valid, slot_index, status, found_zoom, found_x, found_y,
                    found_scheme, occupied, output ready);
endinterface

interface tst_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/tst_ram.sv
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/tst_ctrl.sv
module tst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tst_pkg::dp_cmd_t  cmd,
    input  tst_pkg::dp_stat_t stat
);
    tst_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tst_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tst_pkg::S_SCAN;
                end
            end
            tst_pkg::S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = tst_pkg::S_WAIT;
                end
            end
            tst_pkg::S_WAIT:   state_next = tst_pkg::S_DECIDE;
            tst_pkg::S_DECIDE:
            begin
                if (stat.cmd == tst_pkg::CMD_LOOKUP && !stat.hit && !stat.zoom_zero)
                begin
                    state_next = tst_pkg::S_SCAN;
                end
                else
                begin
                    state_next = tst_pkg::S_OUT;
                end
            end
            tst_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = tst_pkg::S_IDLE;
                end
            end
            default:           state_next = tst_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            tst_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load     = in_valid;
                cmd.scan_clr = 1'b1;
            end
            tst_pkg::S_SCAN:   cmd.scan_en = 1'b1;
            tst_pkg::S_WAIT:   cmd.scan_en = 1'b0;
            tst_pkg::S_DECIDE:
            begin
                cmd.scan_clr = 1'b1;
                if (stat.cmd == tst_pkg::CMD_LOOKUP && !stat.hit && !stat.zoom_zero)
                begin
                    cmd.ascend = 1'b1;
                end
                else
                begin
                    cmd.commit = 1'b1;
                end
            end
            tst_pkg::S_OUT:    out_valid = 1'b1;
            default:           out_valid = 1'b0;
        endcase
    end
endmodule

>>> hw/rtl/tst_dp.sv
module tst_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tst_pkg::dp_cmd_t                   cmd,
    output tst_pkg::dp_stat_t                  stat,
    input  logic [1:0]                         in_cmd,
    input  tst_pkg::key_t                      in_key,
    input  logic                               cfg_we,
    input  logic [tst_pkg::CNT_W-1:0]          cfg_data,
    output logic [tst_pkg::SLOT_W-1:0]         res_slot,
    output logic [1:0]                         res_status,
    output tst_pkg::key_t                      res_key,
    output logic [tst_pkg::CNT_W-1:0]          res_occ
);
    logic [tst_pkg::SLOTS-1:0]   valid_reg;
    logic [tst_pkg::CNT_W-1:0]   occ_reg, limit_reg;
    logic [1:0]                  cmd_reg;
    tst_pkg::key_t               key_reg;
    // scan pointer: address issued; rd pointer is its registered copy
    logic [tst_pkg::CNT_W-1:0]   scan_reg;
    logic                        rd_vld_reg;
    logic [tst_pkg::SLOT_W-1:0]  rd_addr_reg;
    logic                        hit_reg, free_reg;
    logic [tst_pkg::SLOT_W-1:0]  hit_idx_reg, free_idx_reg;
    logic                        ram_we;
    logic [tst_pkg::SLOT_W-1:0]  ram_waddr;
    tst_pkg::key_t               ram_rdata;
    logic                        match;
    logic                        in_range;
    logic [tst_pkg::SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [1:0]                  res_status_reg, res_status_next;
    tst_pkg::key_t               res_key_reg, res_key_next;

    tst_ram #(.WIDTH(tst_pkg::KEY_W), .DEPTH(tst_pkg::SLOTS)) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (scan_reg[tst_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_we    = cmd.commit && cmd_reg == tst_pkg::CMD_ADD && !hit_reg && free_reg;
    assign ram_waddr = free_idx_reg;
    assign in_range  = scan_reg < limit_reg;
    assign match     = rd_vld_reg && valid_reg[rd_addr_reg] && ram_rdata == key_reg;

    assign stat.scan_done = !in_range;
    assign stat.hit       = hit_reg;
    assign stat.zoom_zero = key_reg.zoom == '0;
    assign stat.cmd       = cmd_reg;

    // item capture, ancestor step
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
        end
        else if (cmd.ascend)
        begin
            key_reg.zoom <= key_reg.zoom - 5'd1;
            key_reg.x    <= key_reg.x >> 1;
            key_reg.y    <= key_reg.y >> 1;
        end
    end

    // slot scan with registered key read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            rd_addr_reg  <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        else if (cmd.scan_clr)
        begin
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
            // flags survive a commit; cleared on a new item or a new level
            if (!cmd.commit)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
        end
        else
        begin
            rd_vld_reg  <= cmd.scan_en && in_range;
            rd_addr_reg <= scan_reg[tst_pkg::SLOT_W-1:0];
            if (cmd.scan_en && in_range)
            begin
                scan_reg <= scan_reg + 9'd1;
            end
            if (rd_vld_reg)
            begin
                if (match && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_addr_reg;
                end
                if (!valid_reg[rd_addr_reg] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_addr_reg;
                end
            end
        end
    end

    // table state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            limit_reg <= tst_pkg::LIMIT_CAP;
        end
        else
        begin
            if (cfg_we && occ_reg == '0)
            begin
                if (cfg_data == '0)
                begin
                    limit_reg <= 9'd1;
                end
                else if (cfg_data > tst_pkg::LIMIT_CAP)
                begin
                    limit_reg <= tst_pkg::LIMIT_CAP;
                end
                else
                begin
                    limit_reg <= cfg_data;
                end
            end
            if (ram_we)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg                 <= occ_reg + 9'd1;
            end
            else if (cmd.commit && cmd_reg == tst_pkg::CMD_REMOVE && hit_reg)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
                occ_reg                <= occ_reg - 9'd1;
            end
        end
    end

    // result of the item being committed
    always_comb
    begin
        res_slot_next   = '0;
        res_status_next = tst_pkg::ST_OK;
        res_key_next    = '0;
        case (cmd_reg)
            tst_pkg::CMD_ADD:
            begin
                if (hit_reg)
                begin
                    res_status_next = tst_pkg::ST_DUP;
                end
                else if (free_reg)
                begin
                    res_slot_next = free_idx_reg;
                end
                else
                begin
                    res_status_next = tst_pkg::ST_FULL;
                end
            end
            tst_pkg::CMD_REMOVE, tst_pkg::CMD_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res_slot_next = hit_idx_reg;
                    if (cmd_reg == tst_pkg::CMD_LOOKUP)
                    begin
                        res_key_next = key_reg;
                    end
                end
                else
                begin
                    res_status_next = tst_pkg::ST_ABSENT;
                end
            end
            default:
            begin
                res_status_next = tst_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            res_key_reg    <= res_key_next;
        end
    end

    assign res_slot   = res_slot_reg;
    assign res_status = res_status_reg;
    assign res_key    = res_key_reg;
    assign res_occ    = occ_reg;
endmodule

>>> hw/rtl/tile_slot_table_unit.sv
// Tile slot table: add, remove and ancestor lookup of map tile keys over up to 256
// slots. Each item scans the key memory one slot per cycle up to slot_limit, and a
// lookup repeats the scan once per zoom level tried (up to 32 levels). One item is
// handled at a time; its result is held on the output until taken. slot_limit is
// written only while the table is empty.
module tile_slot_table_unit (
    input logic       clk,
    input logic       rst_n,
    tst_in_if.sink    in_ch,
    tst_out_if.source out_ch,
    tst_cfg_if.sink   cfg
);
    tst_pkg::dp_cmd_t  cmd;
    tst_pkg::dp_stat_t stat;
    tst_pkg::key_t     in_key, res_key;

    // zoom is passed through unchanged; its 5-bit field covers 0 to 31
    assign in_key.zoom   = in_ch.tile_zoom;
    assign in_key.x      = in_ch.tile_x;
    assign in_key.y      = in_ch.tile_y;
    assign in_key.scheme = in_ch.tile_scheme;
    assign cfg.ready     = 1'b1;

    tst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (in_ch.cmd),
        .in_key     (in_key),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .res_slot   (out_ch.slot_index),
        .res_status (out_ch.status),
        .res_key    (res_key),
        .res_occ    (out_ch.occupied)
    );

    assign out_ch.found_zoom   = res_key.zoom;
    assign out_ch.found_x      = res_key.x;
    assign out_ch.found_y      = res_key.y;
    assign out_ch.found_scheme = res_key.scheme;

    // occupancy never exceeds the slot count
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.occupied <= tst_pkg::LIMIT_CAP)
        else $error("occupancy overflow");

    // a new item is never taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken during output");

    // a miss reports slot zero
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == tst_pkg::ST_ABSENT |-> out_ch.slot_index == '0)
        else $error("miss with nonzero slot");
endmodule
